// ----- rtl/core/plb_pkg.sv -----
package plb_pkg;

  localparam int C_W   = 31;
  localparam int T_W   = 29;
  localparam int D_W   = 15;
  localparam int ALB_W = 16;
  localparam int CFG_W = 16;
  localparam int Q_W   = 32;

  localparam logic [C_W-1:0] ONE_Q30        = C_W'(1) << 30;
  localparam logic [29:0]    INV_TWO_PI_Q32 = 30'd683565276;

  typedef enum logic [1:0] {
    CFG_ALBEDO_RED   = 2'd0,
    CFG_ALBEDO_GREEN = 2'd1,
    CFG_ALBEDO_BLUE  = 2'd2,
    CFG_LOBE_EXP     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [Q_W-1:0] brdf_red;
    logic [Q_W-1:0] brdf_green;
    logic [Q_W-1:0] brdf_blue;
    logic [Q_W-1:0] sample_density;
    logic           below_horizon;
    logic           clipped;
  } res_t;

  function automatic logic [C_W-1:0] mul_q30(input logic [C_W-1:0] a,
                                             input logic [C_W-1:0] b);
    logic [2*C_W-1:0] p;
    p = a * b;
    p = p + (2*C_W)'(1 << 29);
    return C_W'(p >> 30);
  endfunction

endpackage

// ----- rtl/core/plb_dot.sv -----
module plb_dot
  import plb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [15:0]  ox,
  input  logic signed [15:0]  oy,
  input  logic signed [15:0]  oz,
  input  logic signed [15:0]  ix,
  input  logic signed [15:0]  iy,
  input  logic signed [15:0]  iz,
  output logic                out_valid,
  output logic [C_W-1:0]      c,
  output logic [D_W-1:0]      d,
  output logic                bh
);

  logic               v1;
  logic signed [31:0] p0, p1, p2;
  logic [D_W-1:0]     d1;
  logic               bh1;
  logic signed [33:0] dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= ox * ix;
      p1  <= oy * iy;
      p2  <= oz * iz;
      d1  <= (oy > iy) ? oy[D_W-1:0] : iy[D_W-1:0];
      bh1 <= (iy <= 16'sd0);
    end
  end

  assign dot = 34'(p1) - 34'(p0) - 34'(p2);

  always_ff @(posedge clk) begin
    if (en) begin
      if (dot < 34'sd0)
        c <= '0;
      else if (dot > 34'sd1073741824)
        c <= ONE_Q30;
      else
        c <= dot[C_W-1:0];
      d  <= d1;
      bh <= bh1;
    end
  end

endmodule

// ----- rtl/core/plb_pow.sv -----
module plb_pow
  import plb_pkg::*;
#(
  parameter int N_W    = 10,
  parameter int SIDE_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [C_W-1:0]    c,
  input  logic [N_W-1:0]    n,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [C_W-1:0]    p,
  output logic [SIDE_W-1:0] side_out
);

  logic [C_W-1:0]    acc  [N_W];
  logic [C_W-1:0]    base [N_W];
  logic [SIDE_W-1:0] side [N_W];
  logic              v    [N_W];

  for (genvar i = 0; i < N_W; i++) begin : g_stage
    logic [C_W-1:0]    a_src, b_src;
    logic [SIDE_W-1:0] s_src;
    logic              v_src;
    if (i == 0) begin : g_first
      assign a_src = ONE_Q30;
      assign b_src = c;
      assign s_src = side_in;
      assign v_src = in_valid;
    end else begin : g_next
      assign a_src = acc[i-1];
      assign b_src = base[i-1];
      assign s_src = side[i-1];
      assign v_src = v[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i]  <= n[i] ? mul_q30(a_src, b_src) : a_src;
        base[i] <= mul_q30(b_src, b_src);
        side[i] <= s_src;
      end
    end
  end

  assign out_valid = v[N_W-1];
  assign p         = acc[N_W-1];
  assign side_out  = side[N_W-1];

endmodule

// ----- rtl/core/plb_scale.sv -----
module plb_scale
  import plb_pkg::*;
#(
  parameter int N_W    = 10,
  parameter int F      = 16,
  parameter int NQ_W   = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [C_W-1:0]             p,
  input  logic [N_W-1:0]             n,
  input  logic [2:0][ALB_W-1:0]      albedo,
  input  logic [D_W-1:0]             d_in,
  input  logic                       bh_in,
  output logic                       out_valid,
  output logic [2:0][NQ_W-1:0]       nq,
  output logic [D_W-1:0]             d_out,
  output logic [Q_W-1:0]             pdf,
  output logic                       pclip,
  output logic                       bh_out
);

  localparam int U_W   = T_W + N_W + 1;
  localparam int NUM_W = U_W + ALB_W + 1;
  localparam int S     = 31 - F;
  localparam int PSH   = 30 - F;

  logic [T_W+30:0]  tprod;
  logic [T_W-1:0]   t;
  logic [U_W-1:0]   u, w;
  logic [U_W:0]     pw;
  logic [NUM_W-1:0] half;
  logic [D_W-1:0]   d1, d2;
  logic             bh1, bh2;
  logic             v1, v2;

  assign tprod = p * INV_TWO_PI_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  assign pw   = ((U_W+1)'(w) + ((U_W+1)'(1) << (29 - F))) >> PSH;
  assign half = NUM_W'(d2) << PSH;

  always_ff @(posedge clk) begin
    if (en) begin
      t   <= T_W'((tprod + (T_W+31)'(33'h080000000)) >> 32);
      d1  <= d_in;
      bh1 <= bh_in;
      u   <= U_W'(t) * U_W'((N_W+1)'(n) + (N_W+1)'(2));
      w   <= U_W'(t) * U_W'((N_W+1)'(n) + (N_W+1)'(1));
      d2  <= d1;
      bh2 <= bh1;
      for (int k = 0; k < 3; k++) begin
        nq[k] <= NQ_W'((NUM_W'(u) * NUM_W'(albedo[k]) + half) >> S);
      end
      pclip  <= |(pw >> 32);
      pdf    <= (|(pw >> 32)) ? '1 : pw[Q_W-1:0];
      d_out  <= d2;
      bh_out <= bh2;
    end
  end

endmodule

// ----- rtl/core/plb_div.sv -----
module plb_div
  import plb_pkg::*;
#(
  parameter int NQ_W   = 48,
  parameter int SIDE_W = 34
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][NQ_W-1:0]  nq,
  input  logic [D_W-1:0]        d,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [2:0][Q_W-1:0]   q,
  output logic [2:0]            sat,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int CMP_W = (NQ_W > D_W + Q_W) ? NQ_W : D_W + Q_W;
  localparam int NST   = Q_W + 1;

  logic [2:0][CMP_W-1:0] rem   [NST];
  logic [2:0][Q_W-1:0]   quo   [NST];
  logic [2:0]            sf    [NST];
  logic [D_W-1:0]        dd    [NST];
  logic [SIDE_W-1:0]     side  [NST];
  logic                  v     [NST];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= (j == 0) ? in_valid : v[(j == 0) ? 0 : j-1];
      end
    end

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            rem[0][k] <= CMP_W'(nq[k]);
            quo[0][k] <= '0;
            sf[0][k]  <= CMP_W'(nq[k]) >= (CMP_W'(d) << Q_W);
          end
          dd[0]   <= d;
          side[0] <= side_in;
        end
      end
    end else begin : g_step
      localparam int B = Q_W - j;
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            if (rem[j-1][k] >= (CMP_W'(dd[j-1]) << B)) begin
              rem[j][k] <= rem[j-1][k] - (CMP_W'(dd[j-1]) << B);
              quo[j][k] <= quo[j-1][k] | (Q_W'(1) << B);
            end else begin
              rem[j][k] <= rem[j-1][k];
              quo[j][k] <= quo[j-1][k];
            end
          end
          sf[j]   <= sf[j-1];
          dd[j]   <= dd[j-1];
          side[j] <= side[j-1];
        end
      end
    end
  end

  assign out_valid = v[NST-1];
  assign q         = quo[NST-1];
  assign sat       = sf[NST-1];
  assign side_out  = side[NST-1];

endmodule

// ----- rtl/core/phong_lobe_brdf_eval.sv -----
// Stages, in order from accepted beat to rsp_valid: 2 dot, one per exponent bit of
//   square-and-multiply, 3 scale, 33 divider, 1 output register.
// Throughput: one beat per cycle while req_stall is low; each stage holds one item,
//   a skid register lets one more beat drain while the output is stalled.
// Reset (rst, synchronous): clears all valid bits, albedo to 65535, exponent to 10.
module phong_lobe_brdf_eval
  import plb_pkg::*;
#(
  parameter int EXPONENT_BITS        = 10,
  parameter int RESULT_FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic signed [15:0]       out_dir_x,
  input  logic signed [15:0]       out_dir_y,
  input  logic signed [15:0]       out_dir_z,
  input  logic signed [15:0]       in_dir_x,
  input  logic signed [15:0]       in_dir_y,
  input  logic signed [15:0]       in_dir_z,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [Q_W-1:0]           brdf_red,
  output logic [Q_W-1:0]           brdf_green,
  output logic [Q_W-1:0]           brdf_blue,
  output logic [Q_W-1:0]           sample_density,
  output logic                     below_horizon,
  output logic                     clipped,
  input  logic                     cfg_wen,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int N_W   = EXPONENT_BITS;
  localparam int F     = RESULT_FRACTION_BITS;
  localparam int U_W   = T_W + N_W + 1;
  localparam int NUM_W = U_W + ALB_W + 1;
  localparam int NQ_W  = NUM_W - (31 - F);
  localparam int DS_W  = Q_W + 2;
  localparam logic [N_W-1:0] EXP_RST = N_W'(10);

  logic [2:0][ALB_W-1:0] albedo;
  logic [N_W-1:0]        lobe_exp;
  logic                  en;

  always_ff @(posedge clk) begin
    if (rst) begin
      albedo   <= {3{16'hFFFF}};
      lobe_exp <= EXP_RST;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALBEDO_RED:   albedo[0] <= cfg_data;
        CFG_ALBEDO_GREEN: albedo[1] <= cfg_data;
        CFG_ALBEDO_BLUE:  albedo[2] <= cfg_data;
        CFG_LOBE_EXP:     lobe_exp  <= N_W'(cfg_data & 16'h03FF);
        default: ;
      endcase
    end
  end

  logic             dv;
  logic [C_W-1:0]   dc;
  logic [D_W-1:0]   dd;
  logic             dbh;

  plb_dot u_dot (
    .clk(clk), .rst(rst), .en(en), .in_valid(req_valid),
    .ox(out_dir_x), .oy(out_dir_y), .oz(out_dir_z),
    .ix(in_dir_x), .iy(in_dir_y), .iz(in_dir_z),
    .out_valid(dv), .c(dc), .d(dd), .bh(dbh)
  );

  logic             pv;
  logic [C_W-1:0]   pp;
  logic [D_W:0]     pside;

  plb_pow #(.N_W(N_W), .SIDE_W(D_W+1)) u_pow (
    .clk(clk), .rst(rst), .en(en), .in_valid(dv), .c(dc), .n(lobe_exp),
    .side_in({dd, dbh}), .out_valid(pv), .p(pp), .side_out(pside)
  );

  logic                  sv;
  logic [2:0][NQ_W-1:0]  snq;
  logic [D_W-1:0]        sd;
  logic [Q_W-1:0]        spdf;
  logic                  spclip, sbh;

  plb_scale #(.N_W(N_W), .F(F), .NQ_W(NQ_W)) u_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv), .p(pp), .n(lobe_exp),
    .albedo(albedo), .d_in(pside[D_W:1]), .bh_in(pside[0]),
    .out_valid(sv), .nq(snq), .d_out(sd), .pdf(spdf), .pclip(spclip), .bh_out(sbh)
  );

  logic                 qv;
  logic [2:0][Q_W-1:0]  qq;
  logic [2:0]           qsat;
  logic [DS_W-1:0]      qside;

  plb_div #(.NQ_W(NQ_W), .SIDE_W(DS_W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(sv), .nq(snq), .d(sd),
    .side_in({spdf, spclip, sbh}), .out_valid(qv), .q(qq), .sat(qsat),
    .side_out(qside)
  );

  res_t fin, out_r, skid;
  logic out_v, skid_v, deliver, fbh;

  assign fbh = qside[0];

  always_comb begin
    fin.below_horizon  = fbh;
    fin.clipped        = !fbh && ((|qsat) || qside[1]);
    fin.brdf_red       = fbh ? '0 : (qsat[0] ? '1 : qq[0]);
    fin.brdf_green     = fbh ? '0 : (qsat[1] ? '1 : qq[1]);
    fin.brdf_blue      = fbh ? '0 : (qsat[2] ? '1 : qq[2]);
    fin.sample_density = fbh ? '0 : qside[DS_W-1:2];
  end

  assign en      = !skid_v;
  assign deliver = en && qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && rsp_stall) begin
      if (deliver) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= deliver;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && rsp_stall) begin
      if (deliver) begin
        skid <= fin;
      end
    end else if (skid_v) begin
      out_r <= skid;
    end else begin
      out_r <= fin;
    end
  end

  assign req_stall      = skid_v;
  assign rsp_valid      = out_v;
  assign brdf_red       = out_r.brdf_red;
  assign brdf_green     = out_r.brdf_green;
  assign brdf_blue      = out_r.brdf_blue;
  assign sample_density = out_r.sample_density;
  assign below_horizon  = out_r.below_horizon;
  assign clipped        = out_r.clipped;

endmodule

// ----- rtl/core/plb_checker.sv -----
module plb_checker
  import plb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [Q_W-1:0]     brdf_red,
  input logic [Q_W-1:0]     brdf_green,
  input logic [Q_W-1:0]     brdf_blue,
  input logic [Q_W-1:0]     sample_density,
  input logic               below_horizon,
  input logic               clipped
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid && !req_stall)
    else $error("valid or stall after reset");

  a_horizon_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && below_horizon |-> brdf_red == '0 && brdf_green == '0 &&
      brdf_blue == '0 && sample_density == '0 && !clipped)
    else $error("below horizon beat with nonzero result");

  a_clip_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && clipped |-> brdf_red == '1 || brdf_green == '1 ||
      brdf_blue == '1 || sample_density == '1)
    else $error("clipped without saturated field");

  a_skid_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("input stalled with empty output");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(brdf_red) && $stable(sample_density))
    else $error("stalled result beat changed");

endmodule

bind phong_lobe_brdf_eval plb_checker u_plb_checker (.*);

// ----- tb/sv/phong_lobe_brdf_eval_tb.sv -----
`timescale 1ns / 1ps

module phong_lobe_brdf_eval_tb;
  import plb_pkg::*;

  localparam int LATENCY   = 49;
  localparam int WDOG_MAX  = 20000;
  localparam logic [63:0] INV2PI = 64'd683565276;

  typedef struct packed {
    logic signed [15:0] ox, oy, oz, ix, iy, iz;
  } dirs_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [15:0] out_dir_x = '0, out_dir_y = '0, out_dir_z = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [Q_W-1:0] brdf_red, brdf_green, brdf_blue, sample_density;
  logic below_horizon, clipped;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  phong_lobe_brdf_eval dut (.*);

  always #5 clk = ~clk;

  logic [15:0] alb_r = 16'hFFFF, alb_g = 16'hFFFF, alb_b = 16'hFFFF;
  logic [9:0]  lobe_n = 10'd10;

  dirs_t pending_dirs[$];
  res_t  expected_res[$];
  int    send_idle_pct = 0, recv_stall_pct = 0;
  bit    hold_off = 0;
  bit    req_taken = 0;
  int    errors = 0;
  int    idle_cycles = 0;

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] clamp32(logic [63:0] v, ref bit clip);
    if (v > 64'hFFFF_FFFF) begin
      clip = 1;
      return 64'hFFFF_FFFF;
    end
    return v;
  endfunction

  function automatic res_t eval_lobe(dirs_t w);
    res_t r;
    longint dot;
    logic [63:0] c, acc, base, t, d, dv, u;
    logic [15:0] alb[3];
    logic [63:0] ch[3];
    bit clip;
    r = '0;
    clip = 0;
    if (w.iy <= 0) begin
      r.below_horizon = 1'b1;
      return r;
    end
    dot = -longint'(w.ox) * w.ix + longint'(w.oy) * w.iy - longint'(w.oz) * w.iz;
    if (dot < 0) c = 0;
    else if (dot > (64'd1 << 30)) c = 64'd1 << 30;
    else c = dot;
    acc = 64'd1 << 30;
    base = c;
    for (int i = 0; i < 10; i++) begin
      if (lobe_n[i]) acc = q30_mul(acc, base);
      base = q30_mul(base, base);
    end
    t = (acc * INV2PI + (64'd1 << 31)) >> 32;
    d = (w.oy > w.iy) ? 64'(w.oy) : 64'(w.iy);
    dv = d << 15;
    u = t * (lobe_n + 64'd2);
    alb[0] = alb_r; alb[1] = alb_g; alb[2] = alb_b;
    for (int k = 0; k < 3; k++)
      ch[k] = clamp32((u * alb[k] + (dv >> 1)) / dv, clip);
    r.brdf_red = ch[0][31:0];
    r.brdf_green = ch[1][31:0];
    r.brdf_blue = ch[2][31:0];
    r.sample_density = clamp32((t * (lobe_n + 64'd1) + (64'd1 << 13)) >> 14, clip);
    r.clipped = clip;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_dirs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        dirs_t w;
        w = pending_dirs.pop_front();
        out_dir_x <= w.ox; out_dir_y <= w.oy; out_dir_z <= w.oz;
        in_dir_x <= w.ix; in_dir_y <= w.iy; in_dir_z <= w.iz;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

  // input monitor: predict at acceptance
  always @(posedge clk) begin
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall)
      expected_res.push_back(eval_lobe({out_dir_x, out_dir_y, out_dir_z,
                                        in_dir_x, in_dir_y, in_dir_z}));
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (brdf_red !== e.brdf_red) begin
          $error("brdf_red exp %0d got %0d", e.brdf_red, brdf_red); errors++;
        end
        if (brdf_green !== e.brdf_green) begin
          $error("brdf_green exp %0d got %0d", e.brdf_green, brdf_green); errors++;
        end
        if (brdf_blue !== e.brdf_blue) begin
          $error("brdf_blue exp %0d got %0d", e.brdf_blue, brdf_blue); errors++;
        end
        if (sample_density !== e.sample_density) begin
          $error("sample_density exp %0d got %0d", e.sample_density, sample_density);
          errors++;
        end
        if (below_horizon !== e.below_horizon) begin
          $error("below_horizon exp %0d got %0d", e.below_horizon, below_horizon);
          errors++;
        end
        if (clipped !== e.clipped) begin
          $error("clipped exp %0d got %0d", e.clipped, clipped); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_ALBEDO_RED:   alb_r = val;
      CFG_ALBEDO_GREEN: alb_g = val;
      CFG_ALBEDO_BLUE:  alb_b = val;
      CFG_LOBE_EXP:     lobe_n = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_dirs.size() > 0 || req_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // mostly near-unit vectors, aimed near the mirror direction
  task automatic push_random(int count);
    dirs_t w;
    for (int i = 0; i < count; i++) begin
      int m;
      m = $urandom_range(9);
      if (m < 2) begin
        w = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
      end else begin
        int a, b, j1, j2;
        a = $urandom_range(20000) - 10000;
        b = $urandom_range(20000) - 10000;
        w.ox = 16'(a); w.oz = 16'(b);
        w.oy = 16'($urandom_range(32767, 20000));
        j1 = (m < 6) ? 40 : 3000;
        j2 = $urandom_range(2 * j1) - j1;
        w.ix = 16'(-a + j2);
        w.iz = 16'(-b - j2);
        w.iy = 16'(int'(w.oy) - $urandom_range(j1));
        if (m == 9) w.iy = 16'($urandom_range(400, 1));
      end
      pending_dirs.push_back(w);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
    pending_dirs.push_back({-16'sd32768, -16'sd32768, -16'sd32768,
                            -16'sd32768, 16'sd32767, -16'sd32768});
    pending_dirs.push_back({16'sd32767, -16'sd32768, 16'sd32767,
                            16'sd32767, 16'sd32767, 16'sd32767});
    pending_dirs.push_back({16'sd23170, 16'sd23170, 16'sd0,
                            -16'sd23170, 16'sd23170, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 16'sd1, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100, 16'sd0});
    drain();
    reg_write(CFG_LOBE_EXP, 16'd0);
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 16'sd1, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd5, 16'sd0});
    drain();
    reg_write(CFG_LOBE_EXP, 16'hFFFF);
    reg_write(CFG_ALBEDO_RED, 16'd0);
    reg_write(CFG_ALBEDO_GREEN, 16'd1);
    reg_write(CFG_ALBEDO_BLUE, 16'h8000);
    pending_dirs.push_back({16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd0});
    pending_dirs.push_back({16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd2, 16'sd0});
    pending_dirs.push_back({16'sd100, 16'sd32000, 16'sd0, -16'sd100, 16'sd32000, 16'sd0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      reg_write(CFG_ALBEDO_RED, 16'($urandom));
      reg_write(CFG_ALBEDO_GREEN, (ph == 1) ? 16'hFFFF : 16'($urandom));
      reg_write(CFG_ALBEDO_BLUE, (ph == 2) ? 16'h0 : 16'($urandom));
      case (ph)
        0: reg_write(CFG_LOBE_EXP, 16'd1);
        4: reg_write(CFG_LOBE_EXP, 16'd1023);
        5: reg_write(CFG_LOBE_EXP, 16'd0);
        default: reg_write(CFG_LOBE_EXP, 16'($urandom_range(200)));
      endcase
      if (ph == 0) begin
        hold_off = 1;
        push_random(100);
        repeat (300) @(negedge clk);
        hold_off = 0;
        push_random(40);
      end else begin
        push_random(140);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/plb_pkg.sv
rtl/core/plb_dot.sv
rtl/core/plb_pow.sv
rtl/core/plb_scale.sv
rtl/core/plb_div.sv
rtl/core/phong_lobe_brdf_eval.sv
rtl/core/plb_checker.sv
tb/sv/phong_lobe_brdf_eval_tb.sv
